// ----- rtl/sstat_pkg.sv -----
// Shared constants, state encoding and command struct for the sample set
// statistics unit. No dependencies; imported by every module of the block.
package sstat_pkg;

    // Set length limit and sample precision.
    localparam int MAX_SAMPLES = 65536;
    localparam int SAMPLE_BITS = 24;

    // Field widths.
    localparam int SMP_W   = 24;
    localparam int CNT_W   = 17;
    localparam int SUM_W   = 40;
    localparam int SQ_W    = 48;
    localparam int SQSUM_W = 64;
    localparam int ROOT_W  = 24;

    localparam logic [SMP_W-1:0] SAMPLE_MASK =
        SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_SAMPLES);

    // Iteration counts of the shared divider and the square root unit.
    localparam int DIV_STEPS  = SQSUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_FLUSH,
        ST_LOAD_MEAN,
        ST_DIV_MEAN,
        ST_LOAD_SQ,
        ST_DIV_SQ,
        ST_VAR,
        ST_SQRT,
        ST_STORE
    } t_state;

    typedef struct packed {
        logic accept;        // take the input sample into the front stage
        logic load_div_mean; // start sum / n
        logic load_div_sq;   // start sum of squares / n
        logic div_step;      // one quotient bit
        logic cap_mean;      // keep the mean quotient
        logic load_sqrt;     // form the variance and start the root
        logic sqrt_step;     // one root bit
        logic store;         // fill the result register, clear the set
    } t_dp_cmd;

endpackage

// ----- rtl/sstat_div.sv -----
// Restoring divider, one quotient bit per cycle while i_step is high: 64-bit
// dividend by a 17-bit divisor. Depends on sstat_pkg.
module sstat_div
    import sstat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [SQSUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]   i_divisor,
    output logic [SQSUM_W-1:0] o_quotient
);

    logic [SQSUM_W-1:0] r_work;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               qbit;

    assign trial = {r_rem, r_work[SQSUM_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign qbit  = (trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (i_step) begin
            r_work <= {r_work[SQSUM_W-2:0], qbit};
            r_rem  <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_quotient = r_work;

endmodule

// ----- rtl/sstat_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle while i_step is
// high, 48-bit radicand. Depends on sstat_pkg.
module sstat_sqrt
    import sstat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [SQ_W-1:0]   i_radicand,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 2;

    logic [SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              take;

    // Bring down the next two radicand bits, try root*4+1.
    assign cur   = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign trial = (REM_W+2)'({r_root, 2'b01});
    assign take  = (cur >= trial);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_step) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= take ? REM_W'(cur - trial) : REM_W'(cur);
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_root = r_root;

endmodule

// ----- rtl/sstat_datapath.sv -----
// Datapath: square stage, accumulators, min/max, shared divider, square
// root and result register. Depends on sstat_pkg, sstat_div, sstat_sqrt.
module sstat_datapath
    import sstat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [SMP_W-1:0]   i_sample,
    output logic [CNT_W-1:0]   o_sample_total,
    output logic [SMP_W-1:0]   o_mean_value,
    output logic [SQ_W-1:0]    o_variance_value,
    output logic [ROOT_W-1:0]  o_deviation_value,
    output logic [SMP_W-1:0]   o_min_value,
    output logic [SMP_W-1:0]   o_max_value,
    output logic               o_overflow_flag
);

    logic [SMP_W-1:0]   smp_masked;
    logic               r_s1_valid;
    logic [SMP_W-1:0]   r_s1_sample;
    logic [SQ_W-1:0]    r_s1_square;

    logic [SUM_W-1:0]   r_sum;
    logic [SQSUM_W-1:0] r_sqsum;
    logic [CNT_W-1:0]   r_count;
    logic [SMP_W-1:0]   r_min;
    logic [SMP_W-1:0]   r_max;
    logic               r_ovf;

    logic [SMP_W-1:0]   r_mean;
    logic [SQ_W-1:0]    r_mean_sq;
    logic [SQ_W-1:0]    r_var;

    logic [SQSUM_W-1:0] div_dividend;
    logic [CNT_W-1:0]   div_divisor;
    logic [SQSUM_W-1:0] quotient;
    logic [SQ_W-1:0]    n_var;
    logic [ROOT_W-1:0]  root;

    assign smp_masked = i_sample & SAMPLE_MASK;

    // Front stage: square each sample ahead of the accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.accept;
        end
        r_s1_sample <= smp_masked;
        r_s1_square <= smp_masked * smp_masked;
    end

    // Accumulators; samples beyond the limit only raise the overflow mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.store) begin
            r_sum   <= '0;
            r_sqsum <= '0;
            r_count <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_ovf   <= 1'b0;
        end else if (r_s1_valid) begin
            if (r_count < COUNT_LIMIT) begin
                r_sum   <= r_sum + SUM_W'(r_s1_sample);
                r_sqsum <= r_sqsum + SQSUM_W'(r_s1_square);
                r_count <= r_count + CNT_W'(1);
                if (r_s1_sample < r_min) begin
                    r_min <= r_s1_sample;
                end
                if (r_s1_sample > r_max) begin
                    r_max <= r_s1_sample;
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign div_dividend = i_cmd.load_div_sq ? r_sqsum : SQSUM_W'(r_sum);
    assign div_divisor  = (r_count == '0) ? CNT_W'(1) : r_count;

    sstat_div u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_div_mean | i_cmd.load_div_sq),
        .i_step     (i_cmd.div_step),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quotient)
    );

    // Variance = floor(sumsq / n) - mean^2, clamped at zero.
    assign n_var = (quotient[SQ_W-1:0] > r_mean_sq) ?
                   quotient[SQ_W-1:0] - r_mean_sq : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_mean) begin
            r_mean <= quotient[SMP_W-1:0];
        end
        r_mean_sq <= r_mean * r_mean;
        if (i_cmd.load_sqrt) begin
            r_var <= n_var;
        end
    end

    sstat_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_sqrt),
        .i_step     (i_cmd.sqrt_step),
        .i_radicand (n_var),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            o_sample_total    <= r_count;
            o_mean_value      <= r_mean;
            o_variance_value  <= r_var;
            o_deviation_value <= root;
            o_min_value       <= r_min;
            o_max_value       <= r_max;
            o_overflow_flag   <= r_ovf;
        end
    end

endmodule

// ----- rtl/sstat_ctrl.sv -----
// Controller: sequences accumulate, divide, root and store, and owns the
// handshakes. Depends on sstat_pkg.
module sstat_ctrl
    import sstat_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              slot_free;
    logic              div_done;
    logic              sqrt_done;

    assign accept    = i_in_valid && (r_state == ST_ACCUM);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign div_done  = (r_step == STEP_W'(DIV_STEPS - 1));
    assign sqrt_done = (r_step == STEP_W'(SQRT_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCUM:     if (accept && i_last) n_state = ST_FLUSH;
            ST_FLUSH:     n_state = ST_LOAD_MEAN;
            ST_LOAD_MEAN: n_state = ST_DIV_MEAN;
            ST_DIV_MEAN:  if (div_done) n_state = ST_LOAD_SQ;
            ST_LOAD_SQ:   n_state = ST_DIV_SQ;
            ST_DIV_SQ:    if (div_done) n_state = ST_VAR;
            ST_VAR:       n_state = ST_SQRT;
            ST_SQRT:      if (sqrt_done) n_state = ST_STORE;
            ST_STORE:     if (slot_free) n_state = ST_ACCUM;
            default:      n_state = ST_ACCUM;
        endcase
    end

    always_comb begin
        o_cmd               = '0;
        o_cmd.accept        = accept;
        n_step              = '0;
        unique case (r_state)
            ST_LOAD_MEAN: o_cmd.load_div_mean = 1'b1;
            ST_DIV_MEAN: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
            end
            ST_LOAD_SQ: begin
                o_cmd.cap_mean    = 1'b1;
                o_cmd.load_div_sq = 1'b1;
            end
            ST_DIV_SQ: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
            end
            ST_VAR:       o_cmd.load_sqrt = 1'b1;
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + STEP_W'(1);
            end
            ST_STORE:     o_cmd.store = slot_free;
            default:      ;
        endcase
    end

    always_comb begin
        priority if (o_cmd.store) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_ACCUM);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/sample_set_statistics_unit.sv -----
// Top level of the sample set statistics unit: controller plus datapath.
// Depends on sstat_pkg, sstat_ctrl, sstat_datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_sample, i_last
//  out     | from block| o_out_valid / i_out_stall| count, mean, variance,
//          |           |                         | deviation, min, max, overflow
//
// Samples that are not last are taken one per cycle while o_in_stall is low:
// each is squared in a front stage and added to the accumulators in the cycle after.
// A last item holds off input until the set is stored: two 64-step passes of
// the shared bit-serial divider, 24 steps of the square root and the states
// that sequence them. The result then sits in the output register while
// the next set is already being taken.
// Reset (synchronous, active low) clears the sequencer, the accumulators
// and the output valid; a held result waits only for i_out_stall to drop.
module sample_set_statistics_unit
    import sstat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [SMP_W-1:0]  i_sample,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CNT_W-1:0]  o_sample_total,
    output logic [SMP_W-1:0]  o_mean_value,
    output logic [SQ_W-1:0]   o_variance_value,
    output logic [ROOT_W-1:0] o_deviation_value,
    output logic [SMP_W-1:0]  o_min_value,
    output logic [SMP_W-1:0]  o_max_value,
    output logic              o_overflow_flag
);

    t_dp_cmd cmd;

    // Sequencer: owns both handshakes and steps the datapath.
    sstat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Arithmetic: accumulate, divide twice, take the root, hold the result.
    sstat_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_sample          (i_sample),
        .o_sample_total    (o_sample_total),
        .o_mean_value      (o_mean_value),
        .o_variance_value  (o_variance_value),
        .o_deviation_value (o_deviation_value),
        .o_min_value       (o_min_value),
        .o_max_value       (o_max_value),
        .o_overflow_flag   (o_overflow_flag)
    );

    // A last item must close the input until the result is stored.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last) |=> o_in_stall)
        else $error("input open after last item");

    // A new result only appears at the end of a set's processing.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.store |-> o_in_stall)
        else $error("result stored while input open");

    // Every delivered set counted at least one sample.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_total != '0))
        else $error("result with empty count");

    // Minimum never exceeds maximum in a delivered result.
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_min_value <= o_max_value))
        else $error("min above max");

endmodule
